FILE: rtl/poly_pkg.sv
`timescale 1ns / 1ps

package poly_pkg;

    // Widths of the datapath
    localparam int P_BITS  = 130;              // p = 2^130 - 5
    localparam int ACC_W   = P_BITS + 1;       // accumulator, kept below 2^131
    localparam int A_W     = ACC_W + 1;        // accumulator plus padded block
    localparam int KEY_W   = 128;
    localparam int BLK_W   = KEY_W + 1;        // block with pad bit
    localparam int DIGIT_W = 8;                // key bits consumed per cycle
    localparam int DIGITS  = KEY_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(DIGITS);
    localparam int PROD_W  = A_W + DIGIT_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int HI_W    = SUM_W - P_BITS;
    localparam int CNT_W   = 5;
    localparam int BYTES   = KEY_W / 8;

    localparam logic [63:0] R_CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [63:0] R_CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    // Register map (64-bit registers at 8-byte strides)
    typedef enum logic [1:0] {
        REG_R_LOW  = 2'd0,
        REG_R_HIGH = 2'd1,
        REG_S_LOW  = 2'd2,
        REG_S_HIGH = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FOLD,
        S_SUB,
        S_TAG
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_MUL,
        ACC_FOLD,
        ACC_SUB,
        ACC_CLEAR
    } t_acc_cmd;

    typedef struct packed {
        t_acc_cmd           cmd;
        logic [BLK_W-1:0]   block;
    } t_acc_ctrl;

    typedef struct packed {
        logic [63:0]        data_high;
        logic [63:0]        data_low;
        logic [CNT_W-1:0]   byte_count;
        logic               last_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_out_item;

    // Keep the valid bytes and append the 0x01 pad byte; counts above 16 act as 16
    function automatic logic [BLK_W-1:0] pad_block(input logic [KEY_W-1:0] data,
                                                   input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] c;
        logic [BLK_W-1:0] blk;
        c   = (count > CNT_W'(BYTES)) ? CNT_W'(BYTES) : count;
        blk = '0;
        for (int i = 0; i < BYTES; i++) begin
            if (CNT_W'(i) < c) begin
                blk[8*i +: 8] = data[8*i +: 8];
            end
        end
        blk = blk | (BLK_W'(1) << {c, 3'b000});
        return blk;
    endfunction

endpackage

FILE: rtl/poly_cfg.sv
`timescale 1ns / 1ps

module poly_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    output logic [poly_pkg::KEY_W-1:0]   o_r_key,
    output logic [poly_pkg::KEY_W-1:0]   o_s_key
);

    logic [63:0]        r_r_low, r_r_high, r_s_low, r_s_high;
    logic               wr_en;
    poly_pkg::t_cfg_reg sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = poly_pkg::t_cfg_reg'(paddr[4:3]);

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_low  <= '0;
            r_r_high <= '0;
            r_s_low  <= '0;
            r_s_high <= '0;
        end else if (wr_en) begin
            case (sel)
                poly_pkg::REG_R_LOW:  r_r_low  <= pwdata;
                poly_pkg::REG_R_HIGH: r_r_high <= pwdata;
                poly_pkg::REG_S_LOW:  r_s_low  <= pwdata;
                poly_pkg::REG_S_HIGH: r_s_high <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (sel)
            poly_pkg::REG_R_LOW:  prdata = r_r_low;
            poly_pkg::REG_R_HIGH: prdata = r_r_high;
            poly_pkg::REG_S_LOW:  prdata = r_s_low;
            poly_pkg::REG_S_HIGH: prdata = r_s_high;
            default:              prdata = '0;
        endcase
    end

    // r is clamped on use
    assign o_r_key = {r_r_high & poly_pkg::R_CLAMP_HIGH, r_r_low & poly_pkg::R_CLAMP_LOW};
    assign o_s_key = {r_s_high, r_s_low};

endmodule

FILE: rtl/poly_acc.sv
`timescale 1ns / 1ps

module poly_acc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  poly_pkg::t_acc_ctrl          i_ctrl,
    input  logic [poly_pkg::KEY_W-1:0]   i_r_key,
    output logic [poly_pkg::ACC_W-1:0]   o_h,
    output logic                         o_last_digit
);

    localparam int ACC_W   = poly_pkg::ACC_W;
    localparam int A_W     = poly_pkg::A_W;
    localparam int KEY_W   = poly_pkg::KEY_W;
    localparam int DIGIT_W = poly_pkg::DIGIT_W;
    localparam int PROD_W  = poly_pkg::PROD_W;
    localparam int SUM_W   = poly_pkg::SUM_W;
    localparam int HI_W    = poly_pkg::HI_W;
    localparam int P_BITS  = poly_pkg::P_BITS;
    localparam int DCNT_W  = poly_pkg::DCNT_W;

    logic [ACC_W-1:0]  r_h, n_h;
    logic [A_W-1:0]    r_a, n_a;
    logic [KEY_W-1:0]  r_rsh, n_rsh;
    logic [DCNT_W-1:0] r_digit, n_digit;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  wsum;
    logic [HI_W-1:0]   hi;
    logic [ACC_W-1:0]  z_next, fold_next, g, sub_next;

    // Horner step: z = z*2^8 + a*digit, bits above 2^130 folded back times 5
    assign prod   = PROD_W'(r_a) * PROD_W'(r_rsh[KEY_W-1 -: DIGIT_W]);
    assign wsum   = SUM_W'({r_h, {DIGIT_W{1'b0}}}) + SUM_W'(prod);
    assign hi     = wsum[SUM_W-1:P_BITS];
    assign z_next = ACC_W'(wsum[P_BITS-1:0]) + ACC_W'({hi, 2'b00}) + ACC_W'(hi);

    // Final reduction: fold bit 130, then one conditional subtract of p
    assign fold_next = ACC_W'(r_h[P_BITS-1:0]) + (r_h[P_BITS] ? ACC_W'(5) : ACC_W'(0));
    assign g         = r_h + ACC_W'(5);
    assign sub_next  = g[P_BITS] ? ACC_W'(g[P_BITS-1:0]) : r_h;

    always_comb begin
        n_h     = r_h;
        n_a     = r_a;
        n_rsh   = r_rsh;
        n_digit = r_digit;
        case (i_ctrl.cmd)
            poly_pkg::ACC_LOAD: begin
                n_a     = A_W'(r_h) + A_W'(i_ctrl.block);
                n_h     = '0;
                n_rsh   = i_r_key;
                n_digit = '0;
            end
            poly_pkg::ACC_MUL: begin
                n_h     = z_next;
                n_rsh   = r_rsh << DIGIT_W;
                n_digit = r_digit + DCNT_W'(1);
            end
            poly_pkg::ACC_FOLD:  n_h = fold_next;
            poly_pkg::ACC_SUB:   n_h = sub_next;
            poly_pkg::ACC_CLEAR: n_h = '0;
            default: ;
        endcase
    end

    // Accumulator and digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= '0;
            r_digit <= '0;
        end else begin
            r_h     <= n_h;
            r_digit <= n_digit;
        end
    end

    // Operand and key shift register
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_rsh <= n_rsh;
    end

    assign o_h          = r_h;
    assign o_last_digit = (r_digit == DCNT_W'(poly_pkg::DIGITS - 1));

endmodule

FILE: rtl/poly1305_mac.sv
`timescale 1ns / 1ps
// A block is taken in the idle state and multiplied, 8 key bits per cycle through the key
// shift register; a last block then passes the fold, subtract and tag states for reduction
// and tag add. A new block waits until the previous one is through; an empty block skips the multiply.
// The tag sits in an output register, so the next block is taken while it waits.
// Reset (synchronous, active low) clears the keys, the accumulator and all control.
module poly1305_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  poly_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output poly_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int ACC_W  = poly_pkg::ACC_W;
    localparam int KEY_W  = poly_pkg::KEY_W;
    localparam int P_BITS = poly_pkg::P_BITS;

    poly_pkg::t_state    r_state, n_state;
    logic                r_last, n_last;
    logic                r_out_valid;
    poly_pkg::t_out_item r_out_data;

    poly_pkg::t_acc_ctrl acc_ctrl;
    logic [KEY_W-1:0]    r_key, s_key;
    logic [ACC_W-1:0]    acc_h;
    logic                last_digit;
    logic                in_acc, cnt_zero, out_free, load_tag;
    logic [KEY_W-1:0]    tag;

    poly_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_r_key (r_key),
        .o_s_key (s_key)
    );

    poly_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (acc_ctrl),
        .i_r_key      (r_key),
        .o_h          (acc_h),
        .o_last_digit (last_digit)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign cnt_zero = (i_in_data.byte_count == '0);
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        case (r_state)
            poly_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_data.last_block;
                    if (!cnt_zero) begin
                        n_state = poly_pkg::S_MUL;
                    end else if (i_in_data.last_block) begin
                        n_state = poly_pkg::S_FOLD;
                    end
                end
            end
            poly_pkg::S_MUL: begin
                if (last_digit) begin
                    n_state = r_last ? poly_pkg::S_FOLD : poly_pkg::S_IDLE;
                end
            end
            poly_pkg::S_FOLD: n_state = poly_pkg::S_SUB;
            poly_pkg::S_SUB:  n_state = poly_pkg::S_TAG;
            poly_pkg::S_TAG: begin
                if (out_free) begin
                    n_state = poly_pkg::S_IDLE;
                end
            end
            default: n_state = poly_pkg::S_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_in_ready     = 1'b0;
        load_tag       = 1'b0;
        acc_ctrl.cmd   = poly_pkg::ACC_HOLD;
        acc_ctrl.block = poly_pkg::pad_block({i_in_data.data_high, i_in_data.data_low},
                                             i_in_data.byte_count);
        case (r_state)
            poly_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && !cnt_zero) begin
                    acc_ctrl.cmd = poly_pkg::ACC_LOAD;
                end
            end
            poly_pkg::S_MUL:  acc_ctrl.cmd = poly_pkg::ACC_MUL;
            poly_pkg::S_FOLD: acc_ctrl.cmd = poly_pkg::ACC_FOLD;
            poly_pkg::S_SUB:  acc_ctrl.cmd = poly_pkg::ACC_SUB;
            poly_pkg::S_TAG: begin
                if (out_free) begin
                    load_tag     = 1'b1;
                    acc_ctrl.cmd = poly_pkg::ACC_CLEAR;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= poly_pkg::S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // Tag = (h mod p) + s mod 2^128
    assign tag = acc_h[KEY_W-1:0] + s_key;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_tag) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_tag) begin
            r_out_data.tag_low  <= tag[63:0];
            r_out_data.tag_high <= tag[127:64];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_tag_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == poly_pkg::S_TAG))
        else $error("tag transaction raised outside the tag state");

    a_empty_block_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && cnt_zero && !i_in_data.last_block |=> r_state == poly_pkg::S_IDLE)
        else $error("empty non-last block started work");

    a_clear_after_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_tag |=> acc_h == '0)
        else $error("accumulator not cleared after tag");

    a_fold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == poly_pkg::S_SUB |-> (!acc_h[P_BITS] || acc_h[P_BITS-1:0] < 5))
        else $error("folded accumulator out of range");

endmodule

FILE: tb/poly1305_mac_tb.sv
`timescale 1ns / 1ps

module poly1305_mac_tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 40;      // well above the last-block latency
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_PRINTED  = 40;

    // p = 2^130 - 5
    localparam logic [129:0] P1305      = {{127{1'b1}}, 3'b011};
    localparam logic [63:0]  CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [63:0]  CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    // RFC 7539 section 2.5.2 key
    localparam logic [63:0] RFC_R_LOW  = 64'h336d555778bed685;
    localparam logic [63:0] RFC_R_HIGH = 64'ha806d542fe52447f;
    localparam logic [63:0] RFC_S_LOW  = 64'hfdb20dfb8a800301;
    localparam logic [63:0] RFC_S_HIGH = 64'h1bf54941aff6bf4a;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    poly_pkg::t_in_item  in_data  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    poly_pkg::t_out_item out_data;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [4:0]          paddr    = '0;
    logic [63:0]         pwdata   = '0;
    logic [63:0]         prdata;
    logic                pready;

    // Key copy and accumulator of the tag predictor
    logic [63:0]  key_r_low  = '0;
    logic [63:0]  key_r_high = '0;
    logic [63:0]  key_s_low  = '0;
    logic [63:0]  key_s_high = '0;
    logic [129:0] acc_h      = '0;

    poly_pkg::t_in_item  stage[$];
    poly_pkg::t_in_item  pending[$];
    poly_pkg::t_out_item tag_expected[$];
    poly_pkg::t_out_item tag_want;

    int   n_errors       = 0;
    int   n_blocks_sent  = 0;
    int   n_tags_seen    = 0;
    int   n_keys         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_on    = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   cycles         = 0;

    poly1305_mac dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Fold the bits above 2^130 back in as times 5, then one final subtract
    function automatic logic [129:0] reduce_p(input logic [259:0] x);
        logic [259:0] v;
        v = x;
        while (v[259:130] != '0) begin
            v = 260'(v[129:0]) + 260'(v[259:130]) * 260'd5;
        end
        if (v[129:0] >= P1305) begin
            v[129:0] = v[129:0] - P1305;
        end
        return v[129:0];
    endfunction

    // Absorb one block; on a last block queue the tag and clear the accumulator
    function automatic void mac_accept(input poly_pkg::t_in_item it);
        logic [127:0]        data;
        logic [128:0]        blk;
        logic [127:0]        r_clamped;
        logic [127:0]        sum;
        poly_pkg::t_out_item tag;
        int unsigned         n;
        data = {it.data_high, it.data_low};
        n = (it.byte_count > 5'd16) ? 16 : it.byte_count;
        if (n != 0) begin
            blk = '0;
            for (int b = 0; b < n; b++) begin
                blk[8*b +: 8] = data[8*b +: 8];
            end
            blk[8*n] = 1'b1;
            r_clamped = {key_r_high & CLAMP_HIGH, key_r_low & CLAMP_LOW};
            acc_h = reduce_p((260'(acc_h) + 260'(blk)) * 260'(r_clamped));
        end
        if (it.last_block) begin
            sum = acc_h[127:0] + {key_s_high, key_s_low};
            tag.tag_low  = sum[63:0];
            tag.tag_high = sum[127:64];
            tag_expected.push_back(tag);
            acc_h = '0;
        end
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic apb_write(input poly_pkg::t_cfg_reg idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            poly_pkg::REG_R_LOW:  key_r_low  = val;
            poly_pkg::REG_R_HIGH: key_r_high = val;
            poly_pkg::REG_S_LOW:  key_s_low  = val;
            poly_pkg::REG_S_HIGH: key_s_high = val;
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
        apb_write(poly_pkg::REG_R_LOW, rl);
        apb_write(poly_pkg::REG_R_HIGH, rh);
        apb_write(poly_pkg::REG_S_LOW, sl);
        apb_write(poly_pkg::REG_S_HIGH, sh);
        n_keys++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void stage_item(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] count, input logic last);
        poly_pkg::t_in_item it;
        it.data_low   = lo;
        it.data_high  = hi;
        it.byte_count = count;
        it.last_block = last;
        stage.push_back(it);
    endfunction

    // One message of n_blocks blocks, with an occasional ignored empty block mixed in
    function automatic void queue_message(input int n_blocks);
        int count;
        for (int b = 0; b < n_blocks; b++) begin
            if ($urandom_range(19) == 0) begin
                stage_item(rand_word(), rand_word(), 5'd0, 1'b0);
            end
            if (b == n_blocks - 1) begin
                count = ($urandom_range(2) == 0) ? 16 : $urandom_range(31);
            end else begin
                count = ($urandom_range(4) != 0) ? 16 : $urandom_range(1, 31);
            end
            stage_item(rand_word(), rand_word(), 5'(count), b == n_blocks - 1);
        end
    endfunction

    function automatic void fill_random(input int n_items, input int max_blocks);
        int placed;
        int k;
        placed = 0;
        while (placed < n_items) begin
            k = $urandom_range(1, max_blocks);
            queue_message(k);
            placed += k;
        end
    endfunction

    // Hand the staged items to the driver, then wait until the block is drained
    task automatic run_phase(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        foreach (stage[k]) begin
            pending.push_back(stage[k]);
        end
        stage.delete();
        do @(negedge i_clk);
        while (pending.size() != 0 || in_valid || tag_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: one item per transaction, idle gaps at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                mac_accept(in_data);
                n_blocks_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Tag monitor: compare each transaction with the oldest expected tag
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (tag_expected.size() == 0) begin
                    report_error($sformatf("tag %h_%h with no message pending",
                                           out_data.tag_high, out_data.tag_low));
                end else begin
                    tag_want = tag_expected.pop_front();
                    if (out_data.tag_low !== tag_want.tag_low) begin
                        report_error($sformatf("tag_low %h, expected %h",
                                               out_data.tag_low, tag_want.tag_low));
                    end
                    if (out_data.tag_high !== tag_want.tag_high) begin
                        report_error($sformatf("tag_high %h, expected %h",
                                               out_data.tag_high, tag_want.tag_high));
                    end
                    n_tags_seen++;
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long output hold-off, once, while the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_on && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, count edges, masked bytes, RFC vector, open message
        load_key(RFC_R_LOW, RFC_R_HIGH, RFC_S_LOW, RFC_S_HIGH);
        stage_item('0, '0, 5'd0, 1'b1);
        stage_item('1, '1, 5'd0, 1'b0);
        stage_item('1, '1, 5'd16, 1'b1);
        stage_item('1, '1, 5'd1, 1'b1);
        stage_item('1, '1, 5'd7, 1'b1);
        stage_item('1, '1, 5'd8, 1'b1);
        stage_item('1, '1, 5'd15, 1'b1);
        stage_item(rand_word(), rand_word(), 5'd17, 1'b1);
        stage_item('1, '1, 5'd31, 1'b1);
        stage_item(64'h72676f7470797243, 64'h6f46206369687061, 5'd16, 1'b0);
        stage_item(64'h65736552206d7572, 64'h6f72472068637261, 5'd16, 1'b0);
        stage_item(64'h0000000000007075, '1, 5'd2, 1'b1);
        stage_item('0, '0, 5'd16, 1'b0);
        stage_item('1, '1, 5'd0, 1'b1);
        stage_item('1, '1, 5'd16, 1'b0);
        stage_item('1, '1, 5'd16, 1'b0);
        stage_item('1, '1, 5'd9, 1'b1);
        // left open: the next key finishes this message
        stage_item(rand_word(), rand_word(), 5'd16, 1'b0);
        run_phase(0, 0);

        // All-ones key, no idling
        load_key('1, '1, '1, '1);
        fill_random(130, 6);
        run_phase(0, 0);

        // Random key, sender idles
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        fill_random(130, 6);
        run_phase(56, 0);

        // All-zero key, receiver stalls
        load_key('0, '0, '0, '0);
        fill_random(60, 4);
        run_phase(0, 56);

        // Random key, both sides idle
        load_key(rand_word(), rand_word(), rand_word(), rand_word());
        fill_random(130, 6);
        run_phase(26, 26);

        // Short messages at full rate with a long output hold-off
        load_key({$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
        fill_random(130, 2);
        @(negedge i_clk);
        pressure_on = 1'b1;
        run_phase(0, 26);
        pressure_on = 1'b0;

        // Random r key and s key with a zero low half, receiver stalls
        load_key({$urandom, $urandom}, {$urandom, $urandom}, '0, {$urandom, $urandom});
        fill_random(120, 6);
        run_phase(0, 56);

        $display("Sent %0d blocks and checked %0d tags under %0d keys,",
                 n_blocks_sent, n_tags_seen, n_keys);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
